FILE: rtl/ple_pkg.sv
// Shared types and constants for the positional list engine.
// No dependencies.
package ple_pkg;

  localparam int unsigned LIST_DEPTH = 64;
  localparam int unsigned POS_W      = 6;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned VAL_W      = 32;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(LIST_DEPTH);

  typedef enum logic [2:0] {
    OP_APPEND     = 3'd0,
    OP_REMOVE_TAIL = 3'd1,
    OP_INSERT     = 3'd2,
    OP_REMOVE_POS = 3'd3,
    OP_READ_HEAD  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]              op;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] head_value;
    logic [1:0]              status;
    logic [CNT_W-1:0]        count;
  } out_item_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic             append_en;
    logic             insert_en;
    logic             remove_en;
    logic [POS_W-1:0] pos;
    logic [CNT_W-1:0] cnt;
  } chain_ctl_t;

endpackage

FILE: rtl/positional_list_engine.sv
// Positional list engine top level: command decode, cell chain, result register.
// Depends on ple_pkg, ple_ctrl and ple_cell.
//
// The list lives in a chain of LIST_DEPTH cells, one entry each; an insert
// or positional remove shifts every entry past the position one cell at
// once, so a command is taken every clock cycle while the input is not
// stalled, and its result appears in the output register in the next cycle.
// The rate of one command per cycle rests on that whole-chain shift; input
// stall follows only a held result that the receiver has not taken.
module positional_list_engine
  import ple_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic                    accept;
  chain_ctl_t              ctl;
  status_e                 status;
  logic [CNT_W-1:0]        cnt_d;
  logic signed [VAL_W-1:0] cell_data [LIST_DEPTH];
  logic signed [VAL_W-1:0] head_d;
  logic                    out_valid_q;
  out_item_t               out_q, out_d;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  ple_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_item_i),
    .ctl_o    (ctl),
    .status_o (status),
    .cnt_d_o  (cnt_d)
  );

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic signed [VAL_W-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = in_item_i.value;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end
    if (i == LIST_DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end
    if (i == 0) begin : g_head
      ple_cell u_cell (
        .clk_i   (clk_i),
        .ctl_i   (ctl),
        .idx_i   (POS_W'(i)),
        .value_i (in_item_i.value),
        .left_i  (left),
        .right_i (right),
        .data_o  (cell_data[i]),
        .next_o  (head_d)
      );
    end else begin : g_body
      ple_cell u_cell (
        .clk_i   (clk_i),
        .ctl_i   (ctl),
        .idx_i   (POS_W'(i)),
        .value_i (in_item_i.value),
        .left_i  (left),
        .right_i (right),
        .data_o  (cell_data[i]),
        .next_o  ()
      );
    end
  end

  always_comb begin
    out_d.head_value = (cnt_d != '0) ? head_d : '0;
    out_d.status     = status;
    out_d.count      = cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.count <= CNT_FULL))
    else $error("count above capacity");

  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == ST_EMPTY) |-> (out_q.count == '0))
    else $error("empty status with elements stored");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == ST_FULL) |-> (out_q.count == CNT_FULL))
    else $error("full status below capacity");

  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.count == '0) |-> (out_q.head_value == '0))
    else $error("nonzero head on empty list");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (out_q.count == $past(ctl.cnt) || out_q.count == $past(ctl.cnt) + 1'b1
                || out_q.count == $past(ctl.cnt) - 1'b1))
    else $error("count moved by more than one");

endmodule

FILE: rtl/ple_cell.sv
// One storage cell of the list chain: holds one entry, loads the new value
// or takes the entry of its left or right neighbor. Depends on ple_pkg.
module ple_cell
  import ple_pkg::*;
(
  input  logic                    clk_i,
  input  chain_ctl_t              ctl_i,
  input  logic [POS_W-1:0]        idx_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  logic signed [VAL_W-1:0] left_i,
  input  logic signed [VAL_W-1:0] right_i,
  output logic signed [VAL_W-1:0] data_o,
  output logic signed [VAL_W-1:0] next_o
);

  logic signed [VAL_W-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctl_i.append_en && ({1'b0, idx_i} == ctl_i.cnt)) begin
      data_d = value_i;
    end
    if (ctl_i.insert_en) begin
      if (idx_i == ctl_i.pos) begin
        data_d = value_i;
      end else if (idx_i > ctl_i.pos) begin
        data_d = left_i;
      end
    end
    if (ctl_i.remove_en && (idx_i >= ctl_i.pos)) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign next_o = data_d;

endmodule

FILE: rtl/ple_ctrl.sv
// Command decode and element count for the list engine; drives the chain
// control word and the status. Depends on ple_pkg.
module ple_ctrl
  import ple_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  in_item_t         item_i,
  output chain_ctl_t       ctl_o,
  output status_e          status_o,
  output logic [CNT_W-1:0] cnt_d_o
);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             full, empty, pos_ok;
  logic             app, ins, rem;
  status_e          status;

  assign full   = (cnt_q == CNT_FULL);
  assign empty  = (cnt_q == '0);
  assign pos_ok = ({1'b0, item_i.position} < cnt_q);

  always_comb begin
    app    = 1'b0;
    ins    = 1'b0;
    rem    = 1'b0;
    status = ST_OK;
    cnt_d  = cnt_q;
    case (item_i.op)
      OP_APPEND: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          app   = 1'b1;
          cnt_d = cnt_q + 1'b1;
        end
      end
      OP_REMOVE_TAIL: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      OP_INSERT: begin
        if (!pos_ok) begin
          status = ST_RANGE;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          ins   = 1'b1;
          cnt_d = cnt_q + 1'b1;
        end
      end
      OP_REMOVE_POS: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (!pos_ok) begin
          status = ST_RANGE;
        end else begin
          rem   = 1'b1;
          cnt_d = cnt_q - 1'b1;
        end
      end
      OP_READ_HEAD: begin
        if (empty) begin
          status = ST_EMPTY;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (accept_i) begin
      cnt_q <= cnt_d;
    end
  end

  assign ctl_o.append_en = accept_i & app;
  assign ctl_o.insert_en = accept_i & ins;
  assign ctl_o.remove_en = accept_i & rem;
  assign ctl_o.pos       = item_i.position;
  assign ctl_o.cnt       = cnt_q;
  assign status_o        = status;
  assign cnt_d_o         = cnt_d;

endmodule

FILE: dv/tb_positional_list_engine.sv
// Self-checking testbench for positional_list_engine: a queue-fed driver,
// a checking monitor and a behavioral list predictor built on an SV queue.
// Depends on ple_pkg and the positional_list_engine RTL.
module tb_positional_list_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import ple_pkg::*;

  localparam int unsigned TOTAL_ITEMS      = 1650;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT      = 400000;
  localparam logic [2:0]  OP_SPARE_LO      = 3'd5;
  localparam logic [2:0]  OP_SPARE_MID     = 3'd6;
  localparam logic [2:0]  OP_SPARE_HI      = 3'd7;

  typedef enum {MIX_GROW, MIX_SHRINK, MIX_CHURN, MIX_NOISE} mix_e;

  typedef struct {
    in_item_t    cmd;
    int unsigned gap;
    bit          wait_idle;
  } cmd_slot_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b1;
  out_item_t out_item_o;

  cmd_slot_t               cmd_backlog[$];
  out_item_t               pending_reports[$];
  logic signed [VAL_W-1:0] list_model[$];

  int unsigned gen_cnt;
  bit          gen_calm;
  int unsigned failures;
  int unsigned reports_checked;
  int unsigned cycle_cnt;
  bit          tx_busy;
  int unsigned tx_wait;
  int unsigned tx_gap;
  int unsigned rx_wait;
  int unsigned rx_run;
  bit          rx_calm;
  logic        long_hold = 1'b0;

  positional_list_engine uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic out_item_t execute_cmd(in_item_t c);
    out_item_t   r;
    status_e     st;
    int unsigned n;
    n  = list_model.size();
    st = ST_OK;
    case (c.op)
      OP_APPEND: begin
        if (n >= LIST_DEPTH) st = ST_FULL;
        else list_model.push_back(c.value);
      end
      OP_REMOVE_TAIL: begin
        if (n == 0) st = ST_EMPTY;
        else void'(list_model.pop_back());
      end
      OP_INSERT: begin
        if (c.position >= n) st = ST_RANGE;
        else if (n >= LIST_DEPTH) st = ST_FULL;
        else list_model.insert(c.position, c.value);
      end
      OP_REMOVE_POS: begin
        if (n == 0) st = ST_EMPTY;
        else if (c.position >= n) st = ST_RANGE;
        else list_model.delete(c.position);
      end
      OP_READ_HEAD: begin
        if (n == 0) st = ST_EMPTY;
      end
      default: ;
    endcase
    r.head_value = (list_model.size() > 0) ? list_model[0] : '0;
    r.status     = st;
    r.count      = CNT_W'(list_model.size());
    return r;
  endfunction

  function automatic int unsigned draw_idle(bit calm);
    if (calm || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(1, 16);
  endfunction

  function automatic int unsigned pick_pos();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (gen_cnt == 0) return $urandom_range(0, 63);
    if (r == 0 && gen_cnt < 64) return $urandom_range(gen_cnt, 63);
    if (r == 1) return 0;
    if (r == 2) return gen_cnt - 1;
    return $urandom_range(0, gen_cnt - 1);
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_cmd(logic [2:0] op, int unsigned pos, logic signed [VAL_W-1:0] val,
                           bit wait_idle);
    cmd_slot_t s;
    s.cmd.op       = op;
    s.cmd.position = POS_W'(pos);
    s.cmd.value    = val;
    s.gap          = draw_idle(gen_calm);
    s.wait_idle    = wait_idle;
    cmd_backlog.push_back(s);
    case (op)
      OP_APPEND:      if (gen_cnt < LIST_DEPTH) gen_cnt++;
      OP_REMOVE_TAIL: if (gen_cnt > 0) gen_cnt--;
      OP_INSERT:      if (pos < gen_cnt && gen_cnt < LIST_DEPTH) gen_cnt++;
      OP_REMOVE_POS:  if (pos < gen_cnt) gen_cnt--;
      default: ;
    endcase
  endtask

  task automatic build_stimulus();
    mix_e        mix;
    int unsigned seg;
    int unsigned add_pct;
    int unsigned rem_pct;
    int unsigned r;
    bit          drain;
    gen_cnt  = 0;
    gen_calm = 1'b0;
    // empty list corner cases and spare opcodes
    queue_cmd(OP_READ_HEAD, 0, '0, 1'b0);
    queue_cmd(OP_REMOVE_TAIL, 0, '0, 1'b0);
    queue_cmd(OP_REMOVE_POS, 0, '0, 1'b0);
    queue_cmd(OP_INSERT, 0, 32'sd5, 1'b0);
    queue_cmd(OP_INSERT, 63, 32'sd6, 1'b0);
    queue_cmd(OP_SPARE_LO, 63, '1, 1'b0);
    queue_cmd(OP_SPARE_MID, 0, '0, 1'b0);
    queue_cmd(OP_SPARE_HI, 21, 32'sh5555_5555, 1'b0);
    // value extremes, head and tail edits, out of range positions
    queue_cmd(OP_APPEND, 0, 32'sh7fff_ffff, 1'b0);
    queue_cmd(OP_APPEND, 63, 32'sh8000_0000, 1'b0);
    queue_cmd(OP_INSERT, 0, '1, 1'b0);
    queue_cmd(OP_INSERT, 1, '0, 1'b0);
    queue_cmd(OP_INSERT, 4, 32'sd7, 1'b0);
    queue_cmd(OP_REMOVE_POS, 63, '0, 1'b0);
    queue_cmd(OP_REMOVE_POS, 3, '0, 1'b0);
    queue_cmd(OP_REMOVE_POS, 0, '0, 1'b0);
    queue_cmd(OP_READ_HEAD, 42, 32'sh1234_5678, 1'b0);
    queue_cmd(OP_APPEND, 0, 32'sh5555_5555, 1'b0);
    queue_cmd(OP_INSERT, 1, 32'shaaaa_aaaa, 1'b0);
    queue_cmd(OP_REMOVE_TAIL, 0, '0, 1'b0);
    queue_cmd(OP_REMOVE_TAIL, 0, '0, 1'b0);
    queue_cmd(OP_REMOVE_POS, 1, '0, 1'b0);
    queue_cmd(OP_REMOVE_TAIL, 0, '0, 1'b0);
    queue_cmd(OP_READ_HEAD, 0, '0, 1'b0);

    drain = 1'b1;
    while (cmd_backlog.size() < TOTAL_ITEMS) begin
      mix      = mix_e'($urandom_range(0, 3));
      seg      = $urandom_range(10, 150);
      gen_calm = ($urandom_range(0, 3) == 0);
      case (mix)
        MIX_GROW:   begin add_pct = 85; rem_pct = 8;  end
        MIX_SHRINK: begin add_pct = 10; rem_pct = 75; end
        default:    begin add_pct = 45; rem_pct = 40; end
      endcase
      repeat (seg) begin
        r = $urandom_range(0, 99);
        if (mix == MIX_NOISE)
          queue_cmd(3'($urandom_range(0, 7)), $urandom_range(0, 63), $urandom, drain);
        else if (r < add_pct)
          queue_cmd($urandom_range(0, 1) ? OP_APPEND : OP_INSERT, pick_pos(), pick_value(),
                    drain);
        else if (r < add_pct + rem_pct)
          queue_cmd($urandom_range(0, 1) ? OP_REMOVE_TAIL : OP_REMOVE_POS, pick_pos(),
                    pick_value(), drain);
        else if (r % 5 == 0)
          queue_cmd(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), pick_pos(), pick_value(),
                    drain);
        else
          queue_cmd(OP_READ_HEAD, pick_pos(), pick_value(), drain);
        drain = ($urandom_range(0, 59) == 0);
      end
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    cmd_slot_t s;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
      tx_busy     = 1'b0;
      tx_wait     = 0;
      tx_gap      = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        pending_reports.push_back(execute_cmd(in_item_i));
        tx_busy = 1'b0;
        tx_wait = tx_gap;
      end
      if (!tx_busy) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (cmd_backlog.size() > 0 &&
                     !(cmd_backlog[0].wait_idle && pending_reports.size() > 0)) begin
          s = cmd_backlog.pop_front();
          in_item_i <= s.cmd;
          tx_gap     = s.gap;
          tx_busy    = 1'b1;
        end
      end
      in_valid_i <= tx_busy;
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp;
    if (!rst_ni) begin
      out_stall_i <= 1'b1;
      rx_wait      = 0;
      rx_run       = 0;
      rx_calm      = 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_reports.size() == 0) begin
          $error("unexpected item: head_value %0d status %0d count %0d",
                 out_item_o.head_value, out_item_o.status, out_item_o.count);
          failures++;
        end else begin
          exp = pending_reports.pop_front();
          if (out_item_o.head_value !== exp.head_value) begin
            $error("head_value: expected %0d, actual %0d", exp.head_value,
                   out_item_o.head_value);
            failures++;
          end
          if (out_item_o.status !== exp.status) begin
            $error("status: expected %0d, actual %0d", exp.status, out_item_o.status);
            failures++;
          end
          if (out_item_o.count !== exp.count) begin
            $error("count: expected %0d, actual %0d", exp.count, out_item_o.count);
            failures++;
          end
        end
        reports_checked++;
        if (rx_run == 0) begin
          rx_calm = ($urandom_range(0, 3) == 0);
          rx_run  = $urandom_range(10, 60);
        end
        rx_run--;
        rx_wait = draw_idle(rx_calm);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_stall_i <= (rx_wait > 0) || long_hold;
    end
  end

  // back-pressure burst so the output register holds and the engine stalls its input
  initial begin
    while (reports_checked < 400) @(posedge clk_i);
    long_hold <= 1'b1;
    repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
    long_hold <= 1'b0;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("tb_positional_list_engine failed");
    $finish;
  end

  initial begin
    build_stimulus();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (cmd_backlog.size() > 0 || tx_busy || pending_reports.size() > 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (failures == 0 && pending_reports.size() == 0) begin
      $display("tb_positional_list_engine passed");
    end else begin
      $display("tb_positional_list_engine failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/ple_pkg.sv
rtl/ple_cell.sv
rtl/ple_ctrl.sv
rtl/positional_list_engine.sv
dv/tb_positional_list_engine.sv
